### rtl/adr_pkg.sv
package adr_pkg;

   // command codes carried on req_tuser
   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_MIX    = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   // sample format codes, any other code decodes as pcm16
   localparam logic [1:0] FMT_PCM16 = 2'd0;
   localparam logic [1:0] FMT_PCM32 = 2'd1;
   localparam logic [1:0] FMT_FLOAT = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CFG_FORMAT   = 2'd0;
   localparam logic [1:0] CFG_CHANNELS = 2'd1;
   localparam logic [1:0] CFG_STEP     = 2'd2;

   // result kinds on rsp_tuser
   localparam logic KIND_RING = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [3:0]  MAX_CHANNELS = 4'd8;
   localparam logic [18:0] STEP_MAX     = 19'd262144;
   localparam logic [16:0] MIC_GAIN     = 17'd45875;
   localparam logic [27:0] FLT_LIM      = 28'd134217727;
   localparam logic signed [23:0] Q_MAX = 24'sd8388607;
   localparam logic signed [23:0] Q_MIN = -24'sd8388608;
   localparam logic signed [35:0] SUM_LIM = 36'sd34359738367;

   // one decoded beat handed from front to back
   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [27:0] q;
      logic               last;
      logic signed [23:0] gain;
      logic [15:0]        offset;
   } item_type;

   // configuration seen by the back end
   typedef struct packed {
      logic [3:0]  channels;
      logic [18:0] step;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_SAT,
      ST_EMIT,
      ST_MOD,
      ST_IDX,
      ST_RD,
      ST_USE
   } back_state_type;

endpackage

### rtl/adr_front.sv
module adr_front (
   input  logic [1:0]       fmt,
   input  logic [1:0]       command,
   input  logic [31:0]      sample,
   input  logic             last_channel,
   input  logic [23:0]      mic_sample,
   input  logic [15:0]      back_offset,
   output adr_pkg::item_type item
);
   import adr_pkg::*;

   logic [7:0]         ex;
   logic [22:0]        man;
   logic [23:0]        mant;
   logic [27:0]        mag;
   logic signed [27:0] fq;
   logic signed [27:0] q;
   logic signed [40:0] prod;

   // float32 bits to q5.23, truncated toward zero, saturated
   always_comb begin
      ex   = sample[30:23];
      man  = sample[22:0];
      mant = {1'b1, man};
      if (ex == 8'd255) begin
         mag = (man != 23'd0) ? 28'd0 : FLT_LIM;
      end else if (ex == 8'd0) begin
         mag = 28'd0;
      end else if (ex >= 8'd131) begin
         mag = FLT_LIM;
      end else if (ex >= 8'd127) begin
         mag = 28'(mant) << 2'(ex - 8'd127);
      end else if (ex <= 8'd103) begin
         mag = 28'd0;
      end else begin
         mag = 28'(mant >> 5'(8'd127 - ex));
      end
      fq = sample[31] ? -$signed(mag) : $signed(mag);
   end

   // format select
   always_comb begin
      case (fmt)
         FMT_PCM32: q = 28'($signed(sample[31:8]));
         FMT_FLOAT: q = fq;
         default:   q = $signed({{4{sample[15]}}, sample[15:0], 8'd0});
      endcase
   end

   // mic gain of 0.7, truncated toward zero
   always_comb begin
      prod = $signed(mic_sample) * $signed(MIC_GAIN);
      if (prod < 0) begin
         prod = prod + 41'sd65535;
      end
   end

   always_comb begin
      item.cmd    = command;
      item.q      = q;
      item.last   = last_channel;
      item.gain   = prod[39:16];
      item.offset = back_offset;
   end

endmodule

### rtl/adr_fifo.sv
module adr_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  adr_pkg::item_type push_item,
   input  logic              pop,
   output adr_pkg::item_type head,
   output logic              empty,
   output logic              full
);
   import adr_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ff;
   logic       wr_in;
   logic       rd_ff;
   logic       rd_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);
   assign head  = entry_ff[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_item;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop from empty queue");

endmodule

### rtl/adr_back.sv
module adr_back #(
   parameter int RING_DEPTH = 32768
) (
   input  logic              clock,
   input  logic              reset,
   input  adr_pkg::cfg_type  cfg,
   input  logic              empty,
   input  adr_pkg::item_type head,
   output logic              pop,
   output logic              clearing,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic              rsp_kind,
   output logic [15:0]       rsp_sample,
   output logic              rsp_valid_res,
   output logic              rsp_last
);
   import adr_pkg::*;

   localparam int AW = $clog2(RING_DEPTH);
   localparam int IW = (AW + 2 > 17) ? AW + 2 : 17;
   localparam logic [AW-1:0] LAST_POS = AW'(RING_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_F  = (AW + 1)'(RING_DEPTH);
   localparam logic [36:0]   DEPTH_X  = 37'(RING_DEPTH);
   localparam logic [IW-1:0] DEPTH_I  = IW'(RING_DEPTH);
   localparam logic [3:0]    DIV_LAST = 4'd8;

   back_state_type     state_ff, state_in;
   item_type           cur_ff, cur_in;
   logic signed [35:0] sum_ff, sum_in;
   logic [15:0]        acc_ff, acc_in;
   logic [35:0]        dvd_ff, dvd_in;
   logic [3:0]         drem_ff, drem_in;
   logic [3:0]         dstep_ff, dstep_in;
   logic               neg_ff, neg_in;
   logic [2:0]         n_ff, n_in;
   logic [2:0]         k_ff, k_in;
   logic signed [23:0] mono_ff, mono_in;
   logic [AW-1:0]      wp_ff, wp_in;
   logic [AW:0]        fill_ff, fill_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [15:0]        off_ff, off_in;
   logic [3:0]         j_ff, j_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [23:0]        ring_mem_ff [RING_DEPTH];
   logic signed [23:0] rd_data_ff;
   logic               otvalid_ff, otvalid_in;
   logic               okind_ff, okind_in;
   logic [15:0]        osample_ff, osample_in;
   logic               ovalid_res_ff, ovalid_res_in;
   logic               olast_ff, olast_in;

   logic               ring_we;
   logic [AW-1:0]      ring_waddr;
   logic [23:0]        ring_wdata;
   logic               out_free;
   logic [3:0]         cnt_c;
   logic [18:0]        step_c;
   logic [19:0]        total;
   logic [2:0]         n_calc;
   logic signed [36:0] sum_wide;
   logic signed [35:0] sum_sat;
   logic [35:0]        dvd_nx;
   logic [3:0]         drem_nx;
   logic [36:0]        mod_sh;
   logic [IW-1:0]      idx_sum;
   logic [IW-1:0]      idx_w;
   logic signed [24:0] mix_wide;
   logic signed [23:0] mix_sat;
   logic               read_ok;

   // q1.23 to int16, scaled by 32767 and truncated toward zero
   function automatic logic [15:0] to_int16(input logic signed [23:0] qv);
      logic signed [39:0] p;
      p = qv * $signed(16'sd32767);
      if (p < 0) begin
         p = p + 40'sd8388607;
      end
      return p[38:23];
   endfunction

   assign clearing = (state_ff == ST_CLEAR);
   assign out_free = !otvalid_ff || rsp_tready;

   // divisor and phase step limits, phase sum and repeat count
   always_comb begin
      if (cfg.channels == 4'd0) begin
         cnt_c = 4'd1;
      end else if (cfg.channels > MAX_CHANNELS) begin
         cnt_c = MAX_CHANNELS;
      end else begin
         cnt_c = cfg.channels;
      end
      step_c = (cfg.step > STEP_MAX) ? STEP_MAX : cfg.step;
      total  = 20'(acc_ff) + 20'(step_c);
      n_calc = (total[19:16] > 4'd4) ? 3'd4 : total[18:16];
   end

   // saturating channel sum
   always_comb begin
      sum_wide = 37'(sum_ff) + 37'(head.q);
      if (sum_wide > 37'(SUM_LIM)) begin
         sum_sat = SUM_LIM;
      end else if (sum_wide < -37'(SUM_LIM)) begin
         sum_sat = -SUM_LIM;
      end else begin
         sum_sat = 36'(sum_wide);
      end
   end

   // four restoring divide steps per cycle
   always_comb begin
      logic [4:0] t;
      dvd_nx  = dvd_ff;
      drem_nx = drem_ff;
      for (int i = 0; i < 4; i++) begin
         t      = {drem_nx, dvd_nx[35]};
         dvd_nx = {dvd_nx[34:0], 1'b0};
         if (t >= {1'b0, cnt_c}) begin
            t         = t - {1'b0, cnt_c};
            dvd_nx[0] = 1'b1;
         end
         drem_nx = t[3:0];
      end
   end

   // offset reduction, ring index, mic mix and read check
   always_comb begin
      mod_sh  = DEPTH_X << j_ff;
      idx_sum = IW'(wp_ff) + DEPTH_I - IW'(off_ff);
      idx_w   = (idx_sum >= DEPTH_I) ? idx_sum - DEPTH_I : idx_sum;
      mix_wide = 25'(rd_data_ff) + 25'(cur_ff.gain);
      if (mix_wide > 25'(Q_MAX)) begin
         mix_sat = Q_MAX;
      end else if (mix_wide < 25'(Q_MIN)) begin
         mix_sat = Q_MIN;
      end else begin
         mix_sat = 24'(mix_wide);
      end
      read_ok = (cur_ff.offset != 16'd0) && (IW'(cur_ff.offset) <= IW'(fill_ff));
   end

   // sequencer next state and datapath
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      sum_in        = sum_ff;
      acc_in        = acc_ff;
      dvd_in        = dvd_ff;
      drem_in       = drem_ff;
      dstep_in      = dstep_ff;
      neg_in        = neg_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      mono_in       = mono_ff;
      wp_in         = wp_ff;
      fill_in       = fill_ff;
      clr_in        = clr_ff;
      off_in        = off_ff;
      j_in          = j_ff;
      idx_in        = idx_ff;
      pop           = 1'b0;
      ring_we       = 1'b0;
      ring_waddr    = wp_ff;
      ring_wdata    = 24'd0;
      otvalid_in    = rsp_tready ? 1'b0 : otvalid_ff;
      okind_in      = okind_ff;
      osample_in    = osample_ff;
      ovalid_res_in = ovalid_res_ff;
      olast_in      = olast_ff;
      case (state_ff)
         ST_CLEAR: begin
            ring_we    = 1'b1;
            ring_waddr = clr_ff;
            clr_in     = clr_ff + AW'(1);
            if (clr_ff == LAST_POS) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               cur_in = head;
               case (head.cmd)
                  CMD_SAMPLE: begin
                     sum_in = sum_sat;
                     if (head.last) begin
                        sum_in   = '0;
                        neg_in   = sum_sat[35];
                        dvd_in   = sum_sat[35] ? 36'(-sum_sat) : 36'(sum_sat);
                        drem_in  = 4'd0;
                        dstep_in = 4'd0;
                        acc_in   = total[15:0];
                        n_in     = n_calc;
                        k_in     = 3'd0;
                        if (n_calc != 3'd0) begin
                           state_in = ST_DIV;
                        end
                     end
                  end
                  CMD_MIX, CMD_READ: begin
                     off_in   = head.offset;
                     j_in     = 4'd15;
                     state_in = ST_MOD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            dvd_in   = dvd_nx;
            drem_in  = drem_nx;
            dstep_in = dstep_ff + 4'd1;
            if (dstep_ff == DIV_LAST) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            if (neg_ff) begin
               mono_in = (dvd_ff > 36'd8388608) ? Q_MIN : -$signed(dvd_ff[23:0]);
            end else begin
               mono_in = (dvd_ff > 36'd8388607) ? Q_MAX : $signed(dvd_ff[23:0]);
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               ring_we       = 1'b1;
               ring_wdata    = mono_ff;
               otvalid_in    = 1'b1;
               okind_in      = KIND_RING;
               osample_in    = to_int16(mono_ff);
               ovalid_res_in = 1'b0;
               olast_in      = (k_ff == n_ff - 3'd1);
               wp_in         = (wp_ff == LAST_POS) ? '0 : wp_ff + AW'(1);
               fill_in       = (fill_ff == DEPTH_F) ? fill_ff : fill_ff + (AW + 1)'(1);
               k_in          = k_ff + 3'd1;
               if (k_ff == n_ff - 3'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MOD: begin
            if (37'(off_ff) >= mod_sh) begin
               off_in = off_ff - mod_sh[15:0];
            end
            j_in = j_ff - 4'd1;
            if (j_ff == 4'd0) begin
               state_in = ST_IDX;
            end
         end
         ST_IDX: begin
            idx_in   = idx_w[AW-1:0];
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_USE;
         end
         ST_USE: begin
            if (cur_ff.cmd == CMD_MIX) begin
               ring_we    = 1'b1;
               ring_waddr = idx_ff;
               ring_wdata = mix_sat;
               state_in   = ST_IDLE;
            end else if (out_free) begin
               otvalid_in    = 1'b1;
               okind_in      = KIND_READ;
               osample_in    = read_ok ? to_int16(rd_data_ff) : 16'd0;
               ovalid_res_in = read_ok;
               olast_in      = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         sum_ff     <= '0;
         acc_ff     <= '0;
         wp_ff      <= '0;
         fill_ff    <= '0;
         clr_ff     <= '0;
         otvalid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sum_ff     <= sum_in;
         acc_ff     <= acc_in;
         wp_ff      <= wp_in;
         fill_ff    <= fill_in;
         clr_ff     <= clr_in;
         otvalid_ff <= otvalid_in;
      end
   end

   // working and output payload registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      dvd_ff        <= dvd_in;
      drem_ff       <= drem_in;
      dstep_ff      <= dstep_in;
      neg_ff        <= neg_in;
      n_ff          <= n_in;
      k_ff          <= k_in;
      mono_ff       <= mono_in;
      off_ff        <= off_in;
      j_ff          <= j_in;
      idx_ff        <= idx_in;
      okind_ff      <= okind_in;
      osample_ff    <= osample_in;
      ovalid_res_ff <= ovalid_res_in;
      olast_ff      <= olast_in;
   end

   // sample ring
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem_ff[ring_waddr] <= ring_wdata;
      end
      rd_data_ff <= ring_mem_ff[idx_ff];
   end

   assign rsp_tvalid    = otvalid_ff;
   assign rsp_kind      = okind_ff;
   assign rsp_sample    = osample_ff;
   assign rsp_valid_res = ovalid_res_ff;
   assign rsp_last      = olast_ff;

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_F) else $error("fill count beyond ring depth");
   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= LAST_POS) else $error("write position beyond ring");
   a_ring_kind: assert property (@(posedge clock) disable iff (reset)
      (otvalid_ff && okind_ff == KIND_RING) |-> !ovalid_res_ff)
      else $error("ring result flagged as valid read");
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !pop) else $error("item taken during clearing pass");

endmodule

### rtl/audio_downmix_decimate_ring.sv
// Downmixes a stream of channel samples to mono, repeats each mono sample zero to four
// times by a phase accumulator and keeps the output in a sample ring that can be mixed
// into and read back. After reset the ring is cleared one entry per cycle, during which
// req_tready stays low. A channel beat that does not end a frame goes through the queue
// into the channel sum. A frame's last beat that repeats its sample at least once adds
// the 4-bit-per-cycle divide by the channel count, a saturation step and the emission of
// each repeated sample, which waits while the result side stalls. Mix and read beats pass
// the 16-step reduction of the offset modulo the ring depth and the registered ring read.
module audio_downmix_decimate_ring #(
   parameter int RING_DEPTH = 32768
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // sample[31:0], mic_sample[55:32], back_offset[71:56]
   input  logic [1:0]  req_tuser,  // command[1:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // sample_out[15:0], valid_res[16], zero[23:17]
   output logic [0:0]  rsp_tuser,  // kind[0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [18:0] csr_wdata
);
   import adr_pkg::*;

   logic [1:0]  fmt_ff;
   logic [3:0]  chan_ff;
   logic [18:0] step_ff;
   cfg_type     cfg;
   item_type    front_item;
   item_type    head;
   logic        push;
   logic        pop;
   logic        empty;
   logic        full;
   logic        clearing;
   logic        rsp_kind;
   logic [15:0] rsp_sample;
   logic        rsp_valid_res;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= FMT_PCM16;
         chan_ff <= 4'd2;
         step_ff <= 19'd21845;
      end else if (csr_we) begin
         case (csr_index)
            CFG_FORMAT:   fmt_ff  <= csr_wdata[1:0];
            CFG_CHANNELS: chan_ff <= csr_wdata[3:0];
            CFG_STEP:     step_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg.channels = chan_ff;
   assign cfg.step     = step_ff;

   // input beat handshake
   assign req_tready = !full && !clearing;
   assign push       = req_tvalid && req_tready;

   adr_front u_front (
      .fmt          (fmt_ff),
      .command      (req_tuser),
      .sample       (req_tdata[31:0]),
      .last_channel (req_tlast),
      .mic_sample   (req_tdata[55:32]),
      .back_offset  (req_tdata[71:56]),
      .item         (front_item)
   );

   adr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   adr_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .empty         (empty),
      .head          (head),
      .pop           (pop),
      .clearing      (clearing),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_kind      (rsp_kind),
      .rsp_sample    (rsp_sample),
      .rsp_valid_res (rsp_valid_res),
      .rsp_last      (rsp_tlast)
   );

   // result beat packing
   assign rsp_tdata = {7'd0, rsp_valid_res, rsp_sample};
   assign rsp_tuser = rsp_kind;

endmodule

### tb/audio_downmix_decimate_ring_chk.sv
module audio_downmix_decimate_ring_chk (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [0:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [18:0] csr_wdata,
   output int          fail_count,
   output int          owed_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import adr_pkg::*;

   localparam int DEPTH = 32768;

   typedef struct {
      logic        kind;
      logic [15:0] pcm;
      logic        ok;
      logic        tail;
   } out_beat_type;

   out_beat_type owed_q[$];

   // model copy of the block state and registers
   logic signed [23:0] ring_mem [DEPTH];
   int unsigned wr_pos;
   int unsigned filled;
   int unsigned phase;
   longint      mix_sum;
   logic [1:0]  fmt_reg;
   logic [3:0]  chan_reg;
   logic [18:0] step_reg;

   function automatic longint sat_q(longint v);
      if (v > longint'(Q_MAX)) return longint'(Q_MAX);
      if (v < longint'(Q_MIN)) return longint'(Q_MIN);
      return v;
   endfunction

   function automatic longint float_q23(logic [31:0] f);
      logic [7:0]  ex;
      longint      mant;
      longint      mag;
      int          e;
      ex = f[30:23];
      mant = longint'({1'b1, f[22:0]});
      if (ex == 8'hFF) begin
         if (f[22:0] != 0) return 0;
         mag = longint'(FLT_LIM);
      end else if (ex == 8'h00) begin
         return 0;
      end else begin
         e = int'(ex) - 127;
         if (e >= 4) mag = longint'(FLT_LIM);
         else if (e >= 0) mag = mant << e;
         else if (-e >= 24) mag = 0;
         else mag = mant >> (-e);
         if (mag > longint'(FLT_LIM)) mag = longint'(FLT_LIM);
      end
      return f[31] ? -mag : mag;
   endfunction

   function automatic longint decode_q23(logic [31:0] raw);
      case (fmt_reg)
         FMT_PCM32: return longint'($signed(raw) >>> 8);
         FMT_FLOAT: return float_q23(raw);
         default:   return longint'($signed(raw[15:0])) * 256;
      endcase
   endfunction

   function automatic logic [15:0] q23_pcm(longint q);
      longint v;
      v = (q * 32767) / 8388608;
      return v[15:0];
   endfunction

   function automatic int unsigned behind(logic [15:0] off);
      return (wr_pos + DEPTH - (int'(off) % DEPTH)) % DEPTH;
   endfunction

   // work out what one accepted request beat produces
   task automatic model_beat(logic [1:0] cmd, logic [31:0] smp, logic lst,
                             logic [23:0] mic, logic [15:0] off);
      longint       cnt;
      longint       mono;
      longint       v;
      int unsigned  stp;
      int unsigned  total;
      int           n;
      int unsigned  pos;
      out_beat_type ob;
      if (cmd == CMD_SAMPLE) begin
         mix_sum = mix_sum + decode_q23(smp);
         if (mix_sum > longint'(SUM_LIM)) mix_sum = longint'(SUM_LIM);
         if (mix_sum < -longint'(SUM_LIM)) mix_sum = -longint'(SUM_LIM);
         if (lst) begin
            cnt = longint'(chan_reg);
            if (cnt < 1) cnt = 1;
            if (cnt > longint'(MAX_CHANNELS)) cnt = longint'(MAX_CHANNELS);
            mono = sat_q(mix_sum / cnt);
            mix_sum = 0;
            stp = (step_reg > STEP_MAX) ? int'(STEP_MAX) : int'(step_reg);
            total = phase + stp;
            n = total >> 16;
            if (n > 4) n = 4;
            phase = total & 32'hFFFF;
            for (int k = 0; k < n; k++) begin
               ring_mem[wr_pos] = mono[23:0];
               wr_pos = (wr_pos + 1 >= DEPTH) ? 0 : wr_pos + 1;
               if (filled < DEPTH) filled++;
               ob.kind = KIND_RING;
               ob.pcm  = q23_pcm(mono);
               ob.ok   = 1'b0;
               ob.tail = (k == n - 1);
               owed_q = {owed_q, ob};
            end
         end
      end else if (cmd == CMD_MIX) begin
         pos = behind(off);
         v = longint'(ring_mem[pos]) + (longint'($signed(mic)) * longint'(MIC_GAIN)) / 65536;
         ring_mem[pos] = 24'(sat_q(v));
      end else if (cmd == CMD_READ) begin
         ob.kind = KIND_READ;
         ob.ok   = (off >= 1) && (int'(off) <= filled);
         ob.pcm  = ob.ok ? q23_pcm(longint'(ring_mem[behind(off)])) : 16'd0;
         ob.tail = 1'b1;
         owed_q = {owed_q, ob};
      end
   endtask

   task automatic report(string what, longint got, longint want);
      $display("%0t ns: %s got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      owed_count = 0;
   end

   always @(posedge clock) begin
      out_beat_type w;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) ring_mem[i] = '0;
         wr_pos = 0;
         filled = 0;
         phase = 0;
         mix_sum = 0;
         fmt_reg = FMT_PCM16;
         chan_reg = 4'd2;
         step_reg = 19'd21845;
         owed_q.delete();
      end else begin
         // result beats against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (owed_q.size() == 0) begin
               report("unexpected result beat", rsp_tdata, 0);
            end else begin
               w = owed_q.pop_front();
               if (rsp_tuser[0] !== w.kind) report("kind", rsp_tuser[0], w.kind);
               if (rsp_tdata[15:0] !== w.pcm) report("sample_out", rsp_tdata[15:0], w.pcm);
               if (rsp_tdata[16] !== w.ok) report("valid_res", rsp_tdata[16], w.ok);
               if (rsp_tdata[23:17] !== 7'd0) report("pad bits", rsp_tdata[23:17], 0);
               if (rsp_tlast !== w.tail) report("last", rsp_tlast, w.tail);
            end
         end
         // register writes
         if (csr_we) begin
            case (csr_index)
               CFG_FORMAT:   fmt_reg = csr_wdata[1:0];
               CFG_CHANNELS: chan_reg = csr_wdata[3:0];
               CFG_STEP:     step_reg = csr_wdata;
               default: ;
            endcase
         end
         // request beats
         if (req_tvalid && req_tready)
            model_beat(req_tuser, req_tdata[31:0], req_tlast, req_tdata[55:32],
                       req_tdata[71:56]);
      end
      owed_count = owed_q.size();
   end

endmodule

### tb/audio_downmix_decimate_ring_tb.sv
module audio_downmix_decimate_ring_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import adr_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [18:0] csr_wdata;
   int          fail_count;
   int          owed_count;

   logic        req_took;
   logic        rsp_took;
   logic        quiet;
   logic [1:0]  cur_fmt;
   int          rsp_hold;
   int          cycles;

   audio_downmix_decimate_ring u_top (.*);

   audio_downmix_decimate_ring_chk u_chk (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // handshake flags sampled at the edge, read at the falling edge
   always @(posedge clock) begin
      req_took <= req_tvalid && req_tready;
      rsp_took <= rsp_tvalid && rsp_tready;
   end

   // result side stalls
   always @(negedge clock) begin
      if (rsp_took) rsp_hold = quiet ? 0 : $urandom_range(0, 17);
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("audio_downmix_decimate_ring: mismatch");
         $finish;
      end
   end

   task automatic send_beat(logic [1:0] cmd, logic [31:0] smp, logic lst,
                            logic [23:0] mic, logic [15:0] off);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tlast  <= lst;
      req_tdata  <= {off, mic, smp};
      do @(negedge clock); while (!req_took);
   endtask

   // block idle: no beat offered, nothing owed, up to three mix beats drained
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (owed_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic configure(logic [1:0] fmt, logic [3:0] chans, logic [18:0] stp);
      drain();
      csr_we <= 1'b1;
      csr_index <= CFG_FORMAT;
      csr_wdata <= 19'(fmt);
      @(negedge clock);
      csr_index <= CFG_CHANNELS;
      csr_wdata <= 19'(chans);
      @(negedge clock);
      csr_index <= CFG_STEP;
      csr_wdata <= stp;
      @(negedge clock);
      csr_we <= 1'b0;
      cur_fmt = fmt;
   endtask

   function automatic logic [31:0] rand_sample();
      if (cur_fmt == FMT_FLOAT && $urandom_range(0, 3) != 0)
         return {1'($urandom), 8'($urandom_range(100, 131)), 23'($urandom)};
      return $urandom;
   endfunction

   function automatic logic [15:0] rand_offset();
      if ($urandom_range(0, 4) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 40));
   endfunction

   // one frame of channel beats, last one marked
   task automatic send_frame(int beats);
      for (int i = 0; i < beats; i++)
         send_beat(CMD_SAMPLE, rand_sample(), i == beats - 1, 24'($urandom), 16'($urandom));
   endtask

   // mostly well formed frames with mixes and reads between them
   task automatic random_run(int items);
      int sent;
      int pick;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            pick = $urandom_range(1, 9);
            send_frame(pick);
            sent += pick;
         end else if (pick < 8) begin
            send_beat(CMD_READ, $urandom, 1'($urandom), 24'($urandom), rand_offset());
            sent++;
         end else begin
            send_beat(CMD_MIX, $urandom, 1'($urandom), 24'($urandom), rand_offset());
            sent++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_SAMPLE;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = CFG_FORMAT;
      csr_wdata = '0;
      quiet = 1'b0;
      cur_fmt = FMT_PCM16;
      rsp_hold = 0;
      cycles = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, pcm16 extremes, reads before and after writes
      send_beat(CMD_READ, 32'd0, 1'b0, 24'd0, 16'd1);
      send_beat(CMD_SAMPLE, 32'h0000_7FFF, 1'b0, 24'd0, 16'd0);
      send_beat(CMD_SAMPLE, 32'hFFFF_7FFF, 1'b1, 24'd0, 16'd0);
      configure(FMT_PCM16, 4'd1, 19'd262144);
      send_beat(CMD_SAMPLE, 32'h0000_8000, 1'b1, 24'd0, 16'd0);
      send_beat(CMD_SAMPLE, 32'h0000_7FFF, 1'b1, 24'd0, 16'd0);
      send_beat(CMD_MIX, 32'd0, 1'b0, 24'h7FFFFF, 16'd1);
      send_beat(CMD_MIX, 32'd0, 1'b0, 24'h800000, 16'd5);
      send_beat(CMD_MIX, 32'd0, 1'b0, 24'h7FFFFF, 16'd0);
      send_beat(CMD_MIX, 32'd0, 1'b0, 24'h123456, 16'hFFFF);
      send_beat(CMD_READ, 32'd0, 1'b0, 24'd0, 16'd1);
      send_beat(CMD_READ, 32'd0, 1'b0, 24'd0, 16'd5);
      send_beat(CMD_READ, 32'd0, 1'b0, 24'd0, 16'd0);
      send_beat(CMD_READ, 32'd0, 1'b0, 24'd0, 16'd9);
      send_beat(CMD_READ, 32'd0, 1'b0, 24'd0, 16'h8000);
      send_beat(2'd3, 32'hFFFF_FFFF, 1'b1, 24'hFFFFFF, 16'hFFFF);
      // pcm32 extremes with the step clamped, count zero acting as one
      configure(FMT_PCM32, 4'd0, 19'd524287);
      send_beat(CMD_SAMPLE, 32'h7FFF_FFFF, 1'b0, 24'd0, 16'd0);
      send_beat(CMD_SAMPLE, 32'h8000_0000, 1'b1, 24'd0, 16'd0);
      // float specials: infinity, nan, denormal, huge, tiny, one
      configure(FMT_FLOAT, 4'd15, 19'd65536);
      send_beat(CMD_SAMPLE, 32'h7F80_0000, 1'b1, 24'd0, 16'd0);
      send_beat(CMD_SAMPLE, 32'hFF80_0000, 1'b1, 24'd0, 16'd0);
      send_beat(CMD_SAMPLE, 32'h7FC0_0001, 1'b1, 24'd0, 16'd0);
      send_beat(CMD_SAMPLE, 32'h0000_0001, 1'b1, 24'd0, 16'd0);
      send_beat(CMD_SAMPLE, 32'hC2C8_0000, 1'b1, 24'd0, 16'd0);
      send_beat(CMD_SAMPLE, 32'h3300_0000, 1'b1, 24'd0, 16'd0);
      send_beat(CMD_SAMPLE, 32'h3F80_0000, 1'b1, 24'd0, 16'd0);

      // random phases over several settings, the second and fourth without idling
      configure(FMT_PCM16, 4'd2, 19'd21845);
      random_run(30);
      quiet = 1'b1;
      configure(FMT_PCM32, 4'd8, 19'd1);
      random_run(20);
      quiet = 1'b0;
      configure(FMT_FLOAT, 4'd3, 19'd98304);
      random_run(15);
      drain();
      random_run(10);
      quiet = 1'b1;
      configure(2'd3, 4'd9, 19'd0);
      random_run(15);
      quiet = 1'b0;
      configure(FMT_PCM16, 4'd4, 19'd200000);
      random_run(20);
      configure(FMT_FLOAT, 4'd1, 19'($urandom_range(1, 262144)));
      random_run(20);

      drain();
      if (fail_count == 0) begin
         $display("audio_downmix_decimate_ring: match");
      end else begin
         $display("audio_downmix_decimate_ring: mismatch");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/adr_pkg.sv
rtl/adr_front.sv
rtl/adr_fifo.sv
rtl/adr_back.sv
rtl/audio_downmix_decimate_ring.sv
tb/audio_downmix_decimate_ring_chk.sv
tb/audio_downmix_decimate_ring_tb.sv
